/* rtl/core/utf8tc_pkg.sv */
// Shared types, constants and the lead-byte decoder for the UTF-8 truncating copy.
package utf8tc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 16'd64;

  localparam logic [BYTE_W-1:0] MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

  // One command from the front end: a complete sequence to emit, or a terminator.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] data;      // bytes in emission order
    logic [1:0]             last_idx;  // number of bytes minus one
    logic                   term;      // terminator word
    logic [LEN_W-1:0]       length;    // copied length, meaningful with term
  } cmd_t;

  // Sequence length announced by a lead byte (1 to 4).
  function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] c);
    logic [2:0] n;
    if (c < ASCII_LIMIT) n = 3'd1;
    else if ((c & MASK_2) == LEAD_2) n = 3'd2;
    else if ((c & MASK_3) == LEAD_3) n = 3'd3;
    else if ((c & MASK_4) == LEAD_4) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

endpackage

/* rtl/core/utf8tc_front.sv */
// Front end: assembles UTF-8 sequences, applies the capacity check, issues commands.
module utf8tc_front
  import utf8tc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [CAP_W-1:0]  capacity,
  output logic              cmd_push,
  output cmd_t              cmd
);

  localparam int unsigned CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

  logic [2:0][BYTE_W-1:0] held;
  logic [1:0]             held_count;
  logic [2:0]             seq_len;
  logic [COUNT_BITS-1:0]  copied;
  logic                   stopped;

  logic [2:0]             n;
  logic                   complete;
  logic                   hold_more;
  logic                   fits;
  logic [CMP_W-1:0]       sum;

  always_comb begin
    hold_more = 1'b0;
    complete  = 1'b0;
    n         = seq_len;
    if (in_valid && (in_byte != NUL_BYTE) && !stopped) begin
      if (seq_len == 3'd0) begin
        n = lead_length(in_byte);
        if (n > 3'd1) hold_more = 1'b1;
        else complete = 1'b1;
      end else if ((3'({1'b0, held_count}) + 3'd1) < seq_len) begin
        hold_more = 1'b1;
      end else begin
        complete = 1'b1;
      end
    end
  end

  assign sum  = CMP_W'(copied) + CMP_W'(n);
  assign fits = sum < CMP_W'(capacity);

  always_comb begin
    cmd          = '0;
    cmd_push     = 1'b0;
    if (in_valid && (in_byte == NUL_BYTE)) begin
      cmd_push    = 1'b1;
      cmd.term    = 1'b1;
      cmd.length  = LEN_W'(copied);
    end else if (complete && fits) begin
      cmd_push     = 1'b1;
      cmd.data     = {in_byte, held[2], held[1], held[0]};
      cmd.last_idx = 2'(n - 3'd1);
      cmd.data[cmd.last_idx] = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      seq_len    <= '0;
      copied     <= '0;
      stopped    <= 1'b0;
    end else if (in_valid && (in_byte == NUL_BYTE)) begin
      held_count <= '0;
      seq_len    <= '0;
      copied     <= '0;
      stopped    <= 1'b0;
    end else if (hold_more) begin
      if (seq_len == 3'd0) begin
        held[0]    <= in_byte;
        held_count <= 2'd1;
        seq_len    <= n;
      end else begin
        held[held_count] <= in_byte;
        held_count       <= held_count + 2'd1;
      end
    end else if (complete) begin
      held_count <= '0;
      seq_len    <= '0;
      if (fits) copied <= copied + COUNT_BITS'(n);
      else stopped <= 1'b1;
    end
  end

endmodule

/* rtl/core/utf8tc_cmd_queue.sv */
// Short show-ahead command queue between the front end and the back end.
module utf8tc_cmd_queue
  import utf8tc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic q_empty,
  output logic q_full
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign head    = entries[rd_ptr];
  assign q_empty = (count == '0);
  assign q_full  = (count == CMD_CNT_W'(CMD_DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/utf8tc_back.sv */
// Back end: splits each command into result words and holds the output register.
module utf8tc_back
  import utf8tc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              head,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              pop,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last,
  output logic [LEN_W-1:0]  length
);

  logic [1:0] idx;
  logic       load;
  logic       final_word;

  assign load       = !q_empty && (!out_valid || pop);
  assign final_word = (idx == head.last_idx);
  assign q_pop      = load && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_word ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.term ? NUL_BYTE : head.data[idx];
      last     <= head.term;
      length   <= head.term ? head.length : '0;
    end
  end

endmodule

/* rtl/core/utf8_safe_truncating_copy.sv */
// Top level of the UTF-8 boundary-safe truncating string copy.
//
// Source bytes arrive on the input queue port: a word is taken at a rising edge
// with push high and full low. Each string ends with a zero byte. The block
// copies bytes out whole UTF-8 sequences at a time, never splitting one, and
// stops copying once a sequence plus the terminator would exceed capacity.
// Every string yields exactly one terminator word (out_byte zero, last high)
// carrying the number of bytes copied in length.
//
// Result words leave through the output queue port: a word is shown while
// empty is low and is taken at a rising edge with pop high. A stalled receiver
// holds the word steady; the front end keeps taking input until the four-entry
// command queue fills, then full rises.
//
// Throughput is one input word per cycle while full is low. With the output side
// idle, the first word of a sequence enters the command queue at the edge that takes
// the byte completing it and then loads into the output register; a sequence of n
// bytes leaves as n words, one word per cycle while pop is high (single output register).
//
// Reset (rst, synchronous) clears all string state, empties both queues and
// sets capacity to 64. capacity sits at APB address 0; the user must write it only
// while the block is idle, which the block itself does not enforce.
module utf8_safe_truncating_copy
  import utf8tc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // Input queue side.
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  // Output queue side.
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last,
  output logic [LEN_W-1:0]  length,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CAP_W-1:0] capacity;
  logic             in_valid;
  logic             cmd_push;
  cmd_t             cmd;
  cmd_t             head;
  logic             q_empty;
  logic             q_full;
  logic             q_pop;
  logic             out_valid;

  // The register file is a single capacity register; other addresses read zero.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? APB_DW'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Any accepted byte can issue at most one command, so a free queue slot is
  // all the front end needs to take a word.
  assign full     = q_full;
  assign in_valid = push && !full;
  assign empty    = !out_valid;

  utf8tc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .capacity (capacity),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  utf8tc_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .q_empty  (q_empty),
    .q_full   (q_full)
  );

  utf8tc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .last      (last),
    .length    (length)
  );

endmodule

/* rtl/core/utf8tc_checker.sv */
// Port-level checker for the UTF-8 truncating copy, bound to the top level.
module utf8tc_checker
  import utf8tc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [BYTE_W-1:0] out_byte,
  input logic              last,
  input logic [LEN_W-1:0]  length
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_term_is_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (out_byte == NUL_BYTE))
    else $error("terminator word carries a nonzero byte");

  a_data_no_length: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> (length == '0))
    else $error("data word carries a nonzero length");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last) && $stable(length)))
    else $error("stalled result word changed");

endmodule

bind utf8_safe_truncating_copy utf8tc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .last     (last),
  .length   (length)
);
